@@ rtl/cwc_pkg.sv @@
// Shared types, widths and helper functions of the changed word classifier.
package cwc_pkg;

	localparam int DATA_W   = 64;
	localparam int LINE_W   = 12;
	localparam int BYTE_W   = 19;
	localparam int WORD_W   = 16;
	localparam int LOW_BITS = 24;
	localparam int LANES    = DATA_W / 8;
	localparam int NBYTE_W  = $clog2(LANES + 1);
	localparam int WC_COUNT = 8;

	typedef enum logic [2:0] {
		WC_TAKEN,
		WC_LINK,
		WC_PREV,
		WC_OTHER,
		WC_LOWONLY,
		WC_ADOPTED,
		WC_OWN,
		WC_CARRIED
	} wc_idx_t;

	typedef struct packed {
		logic [NBYTE_W-1:0]  nbytes;
		logic                changed;
		logic                other;
		logic [WC_COUNT-1:0] wc_inc;
		logic                end_line;
		logic                end_chunk;
	} cwc_cls_t;

	function automatic logic [LINE_W-1:0] sat_inc_line(input logic [LINE_W-1:0] v);
		return (&v) ? v : v + LINE_W'(1);
	endfunction

	function automatic logic [WORD_W-1:0] sat_inc_word(input logic [WORD_W-1:0] v);
		return (&v) ? v : v + WORD_W'(1);
	endfunction

	function automatic logic [BYTE_W-1:0] sat_add_byte(input logic [BYTE_W-1:0] v,
		input logic [NBYTE_W-1:0] n);
		logic [BYTE_W:0] sum;
		sum = {1'b0, v} + (BYTE_W + 1)'(n);
		return sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];
	endfunction

endpackage

@@ rtl/cwc_in_if.sv @@
// Word channel into the classifier.
interface cwc_in_if;
	logic                       valid;
	logic                       ready;
	logic [cwc_pkg::DATA_W-1:0] new_word;
	logic [cwc_pkg::DATA_W-1:0] old_word;
	logic                       taken_bit;
	logic                       link_bit;
	logic                       prev_taken_bit;
	logic                       adopted_bit;
	logic                       own_bit;
	logic                       carried_bit;
	logic                       last_in_line;
	logic                       last_in_chunk;

	modport source (output valid, new_word, old_word, taken_bit, link_bit, prev_taken_bit,
		adopted_bit, own_bit, carried_bit, last_in_line, last_in_chunk, input ready);
	modport sink (input valid, new_word, old_word, taken_bit, link_bit, prev_taken_bit,
		adopted_bit, own_bit, carried_bit, last_in_line, last_in_chunk, output ready);
endinterface

@@ rtl/cwc_out_if.sv @@
// Chunk totals channel out of the classifier.
interface cwc_out_if;
	logic                       valid;
	logic                       ready;
	logic [cwc_pkg::LINE_W-1:0] lines_changed;
	logic [cwc_pkg::BYTE_W-1:0] bytes_changed;
	logic [cwc_pkg::WORD_W-1:0] taken_words;
	logic [cwc_pkg::WORD_W-1:0] link_words;
	logic [cwc_pkg::WORD_W-1:0] prev_taken_words;
	logic [cwc_pkg::WORD_W-1:0] other_words;
	logic [cwc_pkg::WORD_W-1:0] low_only_other_words;
	logic [cwc_pkg::LINE_W-1:0] lines_with_other;
	logic [cwc_pkg::WORD_W-1:0] adopted_words;
	logic [cwc_pkg::WORD_W-1:0] own_words;
	logic [cwc_pkg::WORD_W-1:0] carried_words;

	modport source (output valid, lines_changed, bytes_changed, taken_words, link_words,
		prev_taken_words, other_words, low_only_other_words, lines_with_other,
		adopted_words, own_words, carried_words, input ready);
	modport sink (input valid, lines_changed, bytes_changed, taken_words, link_words,
		prev_taken_words, other_words, low_only_other_words, lines_with_other,
		adopted_words, own_words, carried_words, output ready);
endinterface

@@ rtl/cwc_decode.sv @@
// Difference, changed byte count and class decode of one word.
module cwc_decode (
	input  logic [cwc_pkg::DATA_W-1:0] new_word,
	input  logic [cwc_pkg::DATA_W-1:0] old_word,
	input  logic                       taken_bit,
	input  logic                       link_bit,
	input  logic                       prev_taken_bit,
	input  logic                       adopted_bit,
	input  logic                       own_bit,
	input  logic                       carried_bit,
	input  logic                       last_in_line,
	input  logic                       last_in_chunk,
	output cwc_pkg::cwc_cls_t          cls
);

	logic [cwc_pkg::DATA_W-1:0]  diff;
	logic [cwc_pkg::LANES-1:0]   nz;
	logic [cwc_pkg::NBYTE_W-1:0] nbytes;
	logic                        changed;
	logic                        other;
	logic                        low_only;
	logic [cwc_pkg::WC_COUNT-1:0] inc;

	assign diff = new_word ^ old_word;

	always_comb begin
		nbytes = '0;
		for (int b = 0; b < cwc_pkg::LANES; b++) begin
			nz[b]  = |diff[8*b +: 8];
			nbytes = nbytes + cwc_pkg::NBYTE_W'(nz[b]);
		end
	end

	assign changed  = |nz;
	assign low_only = ~|diff[cwc_pkg::DATA_W-1:cwc_pkg::LOW_BITS];
	assign other    = changed & ~taken_bit & ~link_bit & ~prev_taken_bit;

	always_comb begin
		inc                       = '0;
		inc[cwc_pkg::WC_TAKEN]    = changed & taken_bit;
		inc[cwc_pkg::WC_ADOPTED]  = changed & taken_bit & adopted_bit;
		inc[cwc_pkg::WC_OWN]      = changed & taken_bit & ~adopted_bit & own_bit;
		inc[cwc_pkg::WC_CARRIED]  = changed & taken_bit & ~adopted_bit & ~own_bit & carried_bit;
		inc[cwc_pkg::WC_LINK]     = changed & ~taken_bit & link_bit;
		inc[cwc_pkg::WC_PREV]     = changed & ~taken_bit & ~link_bit & prev_taken_bit;
		inc[cwc_pkg::WC_OTHER]    = other;
		inc[cwc_pkg::WC_LOWONLY]  = other & low_only;
	end

	assign cls.nbytes    = nbytes;
	assign cls.changed   = changed;
	assign cls.other     = other;
	assign cls.wc_inc    = inc;
	assign cls.end_line  = last_in_line;
	assign cls.end_chunk = last_in_chunk;

endmodule

@@ rtl/changed_word_classifier_unit.sv @@
// Top level: decode register, chunk counters and result register.
// Path: a word accepted on word_in is decoded into the stage 1 register; a chunk-end
// word then carries its totals into the result register, which drives result_out.
// Throughput: one word per cycle; only a chunk-end word waits, and only while
// the result register still holds totals not yet taken.
// Reset: arst_n clears stage valid, line flags, all counters and result valid.
module changed_word_classifier_unit (
	input  logic          clk,
	input  logic          arst_n,
	cwc_in_if.sink        word_in,
	cwc_out_if.source     result_out
);

	cwc_pkg::cwc_cls_t            cls;
	cwc_pkg::cwc_cls_t            cls_s1;
	logic                         valid_s1;
	logic                         adv;
	logic                         out_free;

	logic                         line_chg_q;
	logic                         line_oth_q;
	logic [cwc_pkg::LINE_W-1:0]   lines_chg_q;
	logic [cwc_pkg::LINE_W-1:0]   lines_oth_q;
	logic [cwc_pkg::BYTE_W-1:0]   bytes_q;
	logic [cwc_pkg::WORD_W-1:0]   words_q [cwc_pkg::WC_COUNT];

	logic                         line_chg_nx;
	logic                         line_oth_nx;
	logic                         close_line;
	logic [cwc_pkg::LINE_W-1:0]   lines_chg_nx;
	logic [cwc_pkg::LINE_W-1:0]   lines_oth_nx;
	logic [cwc_pkg::BYTE_W-1:0]   bytes_nx;
	logic [cwc_pkg::WORD_W-1:0]   words_nx [cwc_pkg::WC_COUNT];

	logic                         out_valid_q;
	logic [cwc_pkg::LINE_W-1:0]   out_lines_chg_q;
	logic [cwc_pkg::LINE_W-1:0]   out_lines_oth_q;
	logic [cwc_pkg::BYTE_W-1:0]   out_bytes_q;
	logic [cwc_pkg::WORD_W-1:0]   out_words_q [cwc_pkg::WC_COUNT];

	cwc_decode u_decode (
		.new_word       (word_in.new_word),
		.old_word       (word_in.old_word),
		.taken_bit      (word_in.taken_bit),
		.link_bit       (word_in.link_bit),
		.prev_taken_bit (word_in.prev_taken_bit),
		.adopted_bit    (word_in.adopted_bit),
		.own_bit        (word_in.own_bit),
		.carried_bit    (word_in.carried_bit),
		.last_in_line   (word_in.last_in_line),
		.last_in_chunk  (word_in.last_in_chunk),
		.cls            (cls)
	);

	assign out_free      = !out_valid_q || result_out.ready;
	assign adv           = valid_s1 && (!cls_s1.end_chunk || out_free);
	assign word_in.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_in.ready) begin
			valid_s1 <= word_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_in.ready && word_in.valid) begin
			cls_s1 <= cls;
		end
	end

	always_comb begin
		line_chg_nx  = line_chg_q | cls_s1.changed;
		line_oth_nx  = line_oth_q | cls_s1.other;
		close_line   = cls_s1.end_line | cls_s1.end_chunk;
		lines_chg_nx = (close_line && line_chg_nx) ? cwc_pkg::sat_inc_line(lines_chg_q)
			: lines_chg_q;
		lines_oth_nx = (close_line && line_oth_nx) ? cwc_pkg::sat_inc_line(lines_oth_q)
			: lines_oth_q;
		bytes_nx     = cwc_pkg::sat_add_byte(bytes_q, cls_s1.nbytes);
		for (int i = 0; i < cwc_pkg::WC_COUNT; i++) begin
			words_nx[i] = cls_s1.wc_inc[i] ? cwc_pkg::sat_inc_word(words_q[i]) : words_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_chg_q  <= 1'b0;
			line_oth_q  <= 1'b0;
			lines_chg_q <= '0;
			lines_oth_q <= '0;
			bytes_q     <= '0;
			for (int i = 0; i < cwc_pkg::WC_COUNT; i++) begin
				words_q[i] <= '0;
			end
		end else if (adv) begin
			if (cls_s1.end_chunk) begin
				line_chg_q  <= 1'b0;
				line_oth_q  <= 1'b0;
				lines_chg_q <= '0;
				lines_oth_q <= '0;
				bytes_q     <= '0;
				for (int i = 0; i < cwc_pkg::WC_COUNT; i++) begin
					words_q[i] <= '0;
				end
			end else begin
				line_chg_q  <= close_line ? 1'b0 : line_chg_nx;
				line_oth_q  <= close_line ? 1'b0 : line_oth_nx;
				lines_chg_q <= lines_chg_nx;
				lines_oth_q <= lines_oth_nx;
				bytes_q     <= bytes_nx;
				for (int i = 0; i < cwc_pkg::WC_COUNT; i++) begin
					words_q[i] <= words_nx[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && cls_s1.end_chunk) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cls_s1.end_chunk) begin
			out_lines_chg_q <= lines_chg_nx;
			out_lines_oth_q <= lines_oth_nx;
			out_bytes_q     <= bytes_nx;
			for (int i = 0; i < cwc_pkg::WC_COUNT; i++) begin
				out_words_q[i] <= words_nx[i];
			end
		end
	end

	assign result_out.valid                = out_valid_q;
	assign result_out.lines_changed        = out_lines_chg_q;
	assign result_out.bytes_changed        = out_bytes_q;
	assign result_out.taken_words          = out_words_q[cwc_pkg::WC_TAKEN];
	assign result_out.link_words           = out_words_q[cwc_pkg::WC_LINK];
	assign result_out.prev_taken_words     = out_words_q[cwc_pkg::WC_PREV];
	assign result_out.other_words          = out_words_q[cwc_pkg::WC_OTHER];
	assign result_out.low_only_other_words = out_words_q[cwc_pkg::WC_LOWONLY];
	assign result_out.lines_with_other     = out_lines_oth_q;
	assign result_out.adopted_words        = out_words_q[cwc_pkg::WC_ADOPTED];
	assign result_out.own_words            = out_words_q[cwc_pkg::WC_OWN];
	assign result_out.carried_words        = out_words_q[cwc_pkg::WC_CARRIED];

endmodule

@@ rtl/cwc_checker.sv @@
// Port-level checks of the classifier and their bind to the top level.
module cwc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [cwc_pkg::LINE_W-1:0] lines_changed,
	input  logic [cwc_pkg::BYTE_W-1:0] bytes_changed,
	input  logic [cwc_pkg::WORD_W-1:0] taken_words,
	input  logic [cwc_pkg::WORD_W-1:0] other_words,
	input  logic [cwc_pkg::WORD_W-1:0] low_only_other_words,
	input  logic [cwc_pkg::LINE_W-1:0] lines_with_other,
	input  logic [cwc_pkg::WORD_W-1:0] adopted_words
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bytes_changed))
		else $error("stalled result dropped or changed");

	a_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lines_with_other <= lines_changed)
		else $error("more lines with other words than changed lines");

	a_subclass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> low_only_other_words <= other_words && adopted_words <= taken_words)
		else $error("subclass count exceeds its class");

	a_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 20'(bytes_changed) >= 20'(other_words))
		else $error("fewer changed bytes than other words");

endmodule

bind changed_word_classifier_unit cwc_checker u_cwc_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.out_valid            (result_out.valid),
	.out_ready            (result_out.ready),
	.lines_changed        (result_out.lines_changed),
	.bytes_changed        (result_out.bytes_changed),
	.taken_words          (result_out.taken_words),
	.other_words          (result_out.other_words),
	.low_only_other_words (result_out.low_only_other_words),
	.lines_with_other     (result_out.lines_with_other),
	.adopted_words        (result_out.adopted_words)
);
